[rtl/ehsm_pkg.sv]
// ----------------------------------------------------------------------------
// ehsm_pkg
// Shared constants, operation codes and control structs of the entity handle
// slot map.
// ----------------------------------------------------------------------------
package ehsm_pkg;

    // default table geometry
    localparam int MAX_HANDLES_DEF = 1024;
    localparam int SIG_BITS_DEF    = 8;

    // port field widths
    localparam int MODE_W    = 3;
    localparam int KEY_W     = 10;
    localparam int COMP_W    = 3;
    localparam int MASK_W    = 8;
    localparam int SIG_OUT_W = 8;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 11;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_CREATE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TOGGLE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_EXISTS = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MATCH  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DEAD = 2'd2;

    // what the key scanner looks for
    typedef enum logic [1:0] {
        SCAN_FREE  = 2'd0,
        SCAN_SLOT  = 2'd1,
        SCAN_MATCH = 2'd2
    } scan_kind_t;

    // sequencer to scanner
    typedef struct packed {
        logic       start;
        scan_kind_t kind;
    } scan_cmd_t;

    // scanner to sequencer
    typedef struct packed {
        logic done;
        logic hit;
    } scan_stat_t;

endpackage

[rtl/entity_handle_slot_map_unit.sv]
// ----------------------------------------------------------------------------
// entity_handle_slot_map_unit
// Sparse key to dense slot handle table with per slot component signatures.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one transaction of mode, key,
//   component and match_mask. Output channel (out_valid/out_ready) returns
//   one result transaction per input: result_key, found, signature, status
//   and live_count.
//   After reset the block sweeps both memories, one entry per cycle, over
//   all MAX_HANDLES entries; in_ready stays low during that pass.
//   One transaction is worked at a time; in_ready is low while it runs.
//   Exists and toggle read the key map and then the signature directly.
//   Create, delete and match wait on the key scanner, which reads one key
//   map entry per cycle through the single read port of the key map:
//   create scans from key 0 for the first free key, match from the given
//   key upward, and delete for the key bound to the last slot.
//   The result sits in an output register; a new transaction is accepted
//   while it waits. If the receiver stalls, the next result holds in the
//   sequencer until the register is free.
// ----------------------------------------------------------------------------
module entity_handle_slot_map_unit
    import ehsm_pkg::*;
#(
    parameter int MAX_HANDLES    = MAX_HANDLES_DEF,
    parameter int SIGNATURE_BITS = SIG_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [MODE_W-1:0]    mode,
    input  logic [KEY_W-1:0]     key,
    input  logic [COMP_W-1:0]    component,
    input  logic [MASK_W-1:0]    match_mask,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KEY_W-1:0]     result_key,
    output logic                 found,
    output logic [SIG_OUT_W-1:0] signature,
    output logic [STATUS_W-1:0]  status,
    output logic [COUNT_W-1:0]   live_count
);

    localparam int KW = $clog2(MAX_HANDLES);
    localparam int CW = $clog2(MAX_HANDLES + 1);
    localparam int SB = SIGNATURE_BITS;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_LOOK  = 9'b000000100,
        ST_SIGRD = 9'b000001000,
        ST_MOVE  = 9'b000010000,
        ST_ZERO  = 9'b000100000,
        ST_SCAN  = 9'b001000000,
        ST_FREE  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [KW-1:0]       clr_reg, clr_next;
    logic [CW-1:0]       live_reg, live_next;
    logic                out_valid_reg, out_valid_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [COMP_W-1:0]   comp_reg, comp_next;
    logic [SB-1:0]       mask_reg, mask_next;
    logic [KW-1:0]       slot_reg, slot_next;
    logic [KW-1:0]       last_reg, last_next;
    logic [KW-1:0]       res_key_reg, res_key_next;
    logic                res_found_reg, res_found_next;
    logic [SB-1:0]       res_sig_reg, res_sig_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                load_out;
    logic [KEY_W-1:0]    result_key_reg;
    logic                found_reg;
    logic [SIG_OUT_W-1:0] signature_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  live_count_reg;

    logic                accept;
    logic                key_in_range;
    logic [KW-1:0]       in_key;
    logic [SB-1:0]       toggled_sig;

    // memory ports
    logic                k_we;
    logic [KW-1:0]       k_waddr;
    logic [KW:0]         k_wdata;
    logic [KW-1:0]       k_raddr;
    logic [KW:0]         k_rdata;
    logic                s_we;
    logic [KW-1:0]       s_waddr;
    logic [SB-1:0]       s_wdata;
    logic [KW-1:0]       s_raddr;
    logic [SB-1:0]       s_rdata;

    // scanner
    scan_cmd_t           scan_cmd;
    scan_stat_t          scan_stat;
    logic [KW-1:0]       scan_start;
    logic [KW-1:0]       scan_kaddr;
    logic [KW-1:0]       scan_saddr;
    logic [KW-1:0]       hit_key;
    logic [SB-1:0]       hit_sig;

    assign accept       = in_valid && in_ready;
    assign in_ready     = (state_reg == ST_IDLE);
    assign key_in_range = 32'(key) < MAX_HANDLES;
    assign in_key       = KW'(key);
    assign toggled_sig  = s_rdata ^ (SB'(1) << comp_reg);

    ehsm_store #(
        .MAX_HANDLES    (MAX_HANDLES),
        .SIGNATURE_BITS (SIGNATURE_BITS)
    ) u_store (
        .clk     (clk),
        .k_we    (k_we),
        .k_waddr (k_waddr),
        .k_wdata (k_wdata),
        .k_raddr (k_raddr),
        .k_rdata (k_rdata),
        .s_we    (s_we),
        .s_waddr (s_waddr),
        .s_wdata (s_wdata),
        .s_raddr (s_raddr),
        .s_rdata (s_rdata)
    );

    ehsm_scan #(
        .MAX_HANDLES    (MAX_HANDLES),
        .SIGNATURE_BITS (SIGNATURE_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (scan_cmd),
        .start_key (scan_start),
        .mask      (mask_reg),
        .last_slot (last_reg),
        .k_rdata   (k_rdata),
        .s_rdata   (s_rdata),
        .k_raddr   (scan_kaddr),
        .s_raddr   (scan_saddr),
        .stat      (scan_stat),
        .hit_key   (hit_key),
        .hit_sig   (hit_sig)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        live_next       = live_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        comp_next       = comp_reg;
        mask_next       = mask_reg;
        slot_next       = slot_reg;
        last_next       = last_reg;
        res_key_next    = res_key_reg;
        res_found_next  = res_found_reg;
        res_sig_next    = res_sig_reg;
        res_status_next = res_status_reg;
        load_out        = 1'b0;
        k_we            = 1'b0;
        k_waddr         = clr_reg;
        k_wdata         = '0;
        k_raddr         = in_key;
        s_we            = 1'b0;
        s_waddr         = clr_reg;
        s_wdata         = '0;
        s_raddr         = slot_reg;
        scan_cmd.start  = 1'b0;
        scan_cmd.kind   = SCAN_FREE;
        scan_start      = '0;

        case (state_reg)
            // clearing pass over both memories
            ST_CLEAR:
            begin
                k_we     = 1'b1;
                s_we     = 1'b1;
                clr_next = clr_reg + KW'(1);
                if (clr_reg == KW'(MAX_HANDLES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            // take a transaction and dispatch on mode
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next       = mode;
                    key_next        = in_key;
                    comp_next       = component;
                    mask_next       = SB'(match_mask);
                    res_key_next    = '0;
                    res_found_next  = 1'b0;
                    res_sig_next    = '0;
                    res_status_next = STAT_OK;
                    case (mode)
                        MODE_CREATE:
                        begin
                            scan_cmd.start = 1'b1;
                            scan_cmd.kind  = SCAN_FREE;
                            state_next     = ST_SCAN;
                        end
                        MODE_DELETE, MODE_TOGGLE:
                        begin
                            if (key_in_range)
                            begin
                                state_next = ST_LOOK;
                            end
                            else
                            begin
                                res_status_next = STAT_DEAD;
                                state_next      = ST_DONE;
                            end
                        end
                        MODE_EXISTS:
                        begin
                            state_next = key_in_range ? ST_LOOK : ST_DONE;
                        end
                        MODE_MATCH:
                        begin
                            if (key_in_range)
                            begin
                                scan_cmd.start = 1'b1;
                                scan_cmd.kind  = SCAN_MATCH;
                                scan_start     = in_key;
                                state_next     = ST_SCAN;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // key map entry of the addressed key is on the read port
            ST_LOOK:
            begin
                if (!k_rdata[KW])
                begin
                    if (mode_reg != MODE_EXISTS)
                    begin
                        res_status_next = STAT_DEAD;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    slot_next = k_rdata[KW-1:0];
                    if (mode_reg == MODE_DELETE)
                    begin
                        last_next  = KW'(live_reg - CW'(1));
                        s_raddr    = KW'(live_reg - CW'(1));
                        state_next = ST_MOVE;
                    end
                    else
                    begin
                        s_raddr    = k_rdata[KW-1:0];
                        state_next = ST_SIGRD;
                    end
                end
            end

            // signature on the read port: report, flip a bit on toggle
            ST_SIGRD:
            begin
                res_found_next = 1'b1;
                if (mode_reg == MODE_TOGGLE)
                begin
                    s_we         = 1'b1;
                    s_waddr      = slot_reg;
                    s_wdata      = toggled_sig;
                    res_sig_next = toggled_sig;
                end
                else
                begin
                    res_sig_next = s_rdata;
                end
                state_next = ST_DONE;
            end

            // swap-remove: last signature into the hole
            ST_MOVE:
            begin
                s_we       = 1'b1;
                s_waddr    = slot_reg;
                s_wdata    = s_rdata;
                state_next = ST_ZERO;
            end

            // clear the vacated last slot, then find the key bound to it
            ST_ZERO:
            begin
                s_we           = 1'b1;
                s_waddr        = last_reg;
                s_wdata        = '0;
                scan_cmd.start = 1'b1;
                scan_cmd.kind  = SCAN_SLOT;
                state_next     = ST_SCAN;
            end

            // scanner owns the read ports until it reports
            ST_SCAN:
            begin
                k_raddr = scan_kaddr;
                s_raddr = scan_saddr;
                if (scan_stat.done)
                begin
                    state_next = ST_DONE;
                    case (mode_reg)
                        MODE_CREATE:
                        begin
                            if (scan_stat.hit)
                            begin
                                k_we         = 1'b1;
                                k_waddr      = hit_key;
                                k_wdata      = {1'b1, KW'(live_reg)};
                                s_raddr      = KW'(live_reg);
                                res_key_next = hit_key;
                                live_next    = live_reg + CW'(1);
                                state_next   = ST_SIGRD;
                            end
                            else
                            begin
                                res_status_next = STAT_FULL;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (scan_stat.hit)
                            begin
                                k_we    = 1'b1;
                                k_waddr = hit_key;
                                k_wdata = {1'b1, slot_reg};
                            end
                            state_next = ST_FREE;
                        end
                        MODE_MATCH:
                        begin
                            if (scan_stat.hit)
                            begin
                                res_key_next   = hit_key;
                                res_found_next = 1'b1;
                                res_sig_next   = hit_sig;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // free the deleted key
            ST_FREE:
            begin
                k_we       = 1'b1;
                k_waddr    = key_reg;
                k_wdata    = '0;
                live_next  = live_reg - CW'(1);
                state_next = ST_DONE;
            end

            // hand the result to the output register
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // transaction and result payload
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        comp_reg       <= comp_next;
        mask_reg       <= mask_next;
        slot_reg       <= slot_next;
        last_reg       <= last_next;
        res_key_reg    <= res_key_next;
        res_found_reg  <= res_found_next;
        res_sig_reg    <= res_sig_next;
        res_status_reg <= res_status_next;
        if (load_out)
        begin
            result_key_reg <= KEY_W'(res_key_reg);
            found_reg      <= res_found_reg;
            signature_reg  <= SIG_OUT_W'(res_sig_reg);
            status_reg     <= res_status_reg;
            live_count_reg <= COUNT_W'(live_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign result_key = result_key_reg;
    assign found      = found_reg;
    assign signature  = signature_reg;
    assign status     = status_reg;
    assign live_count = live_count_reg;

    // checks
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_reg) <= MAX_HANDLES)
        else $error("live count beyond table size");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("transaction accepted while busy");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    a_scan_owner: assert property (@(posedge clk) disable iff (!rst_n)
        scan_stat.done |-> (state_reg == ST_SCAN))
        else $error("scanner reported while not owning the ports");

endmodule

[rtl/ehsm_store.sv]
// ----------------------------------------------------------------------------
// ehsm_store
// Key map and dense signature memories, one write and one registered read
// port each.
// ----------------------------------------------------------------------------
module ehsm_store
    import ehsm_pkg::*;
#(
    parameter int MAX_HANDLES    = MAX_HANDLES_DEF,
    parameter int SIGNATURE_BITS = SIG_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           k_we,
    input  logic [$clog2(MAX_HANDLES)-1:0] k_waddr,
    input  logic [$clog2(MAX_HANDLES):0]   k_wdata,
    input  logic [$clog2(MAX_HANDLES)-1:0] k_raddr,
    output logic [$clog2(MAX_HANDLES):0]   k_rdata,
    input  logic                           s_we,
    input  logic [$clog2(MAX_HANDLES)-1:0] s_waddr,
    input  logic [SIGNATURE_BITS-1:0]      s_wdata,
    input  logic [$clog2(MAX_HANDLES)-1:0] s_raddr,
    output logic [SIGNATURE_BITS-1:0]      s_rdata
);

    localparam int KW = $clog2(MAX_HANDLES);

    // key map entry: live bit over dense slot index
    logic [KW:0]               kmem [MAX_HANDLES];
    logic [SIGNATURE_BITS-1:0] smem [MAX_HANDLES];
    logic [KW:0]               k_rdata_reg;
    logic [SIGNATURE_BITS-1:0] s_rdata_reg;

    // key map port
    always_ff @(posedge clk)
    begin
        if (k_we)
        begin
            kmem[k_waddr] <= k_wdata;
        end
        k_rdata_reg <= kmem[k_raddr];
    end

    // signature port
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            smem[s_waddr] <= s_wdata;
        end
        s_rdata_reg <= smem[s_raddr];
    end

    assign k_rdata = k_rdata_reg;
    assign s_rdata = s_rdata_reg;

endmodule

[rtl/ehsm_scan.sv]
// ----------------------------------------------------------------------------
// ehsm_scan
// Key scanner: walks keys upward one per cycle through a read pipeline
// (key map, then signature) and stops at the first hit or at the end of the table.
// ----------------------------------------------------------------------------
module ehsm_scan
    import ehsm_pkg::*;
#(
    parameter int MAX_HANDLES    = MAX_HANDLES_DEF,
    parameter int SIGNATURE_BITS = SIG_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  scan_cmd_t                      cmd,
    input  logic [$clog2(MAX_HANDLES)-1:0] start_key,
    input  logic [SIGNATURE_BITS-1:0]      mask,
    input  logic [$clog2(MAX_HANDLES)-1:0] last_slot,
    input  logic [$clog2(MAX_HANDLES):0]   k_rdata,
    input  logic [SIGNATURE_BITS-1:0]      s_rdata,
    output logic [$clog2(MAX_HANDLES)-1:0] k_raddr,
    output logic [$clog2(MAX_HANDLES)-1:0] s_raddr,
    output scan_stat_t                     stat,
    output logic [$clog2(MAX_HANDLES)-1:0] hit_key,
    output logic [SIGNATURE_BITS-1:0]      hit_sig
);

    localparam int KW = $clog2(MAX_HANDLES);
    localparam int SB = SIGNATURE_BITS;

    logic              busy_reg, busy_next;
    scan_kind_t        kind_reg, kind_next;
    logic [KW:0]       cnt_reg, cnt_next;
    logic              s1_vld_reg, s1_vld_next;
    logic [KW-1:0]     s1_key_reg;
    logic              s2_vld_reg, s2_vld_next;
    logic [KW-1:0]     s2_key_reg;
    logic              s2_live_reg;
    logic [KW-1:0]     s2_slot_reg;
    logic              done_reg, done_next;
    logic              hit_reg, hit_next;
    logic [KW-1:0]     hit_key_reg;
    logic [SB-1:0]     hit_sig_reg;
    logic              issue;
    logic              s2_hit;

    // one key address per cycle until the end of the table
    assign issue   = busy_reg && (cnt_reg != (KW+1)'(MAX_HANDLES));
    assign k_raddr = cnt_reg[KW-1:0];
    assign s_raddr = k_rdata[KW-1:0];

    // hit test on the last stage
    always_comb
    begin
        case (kind_reg)
            SCAN_FREE:  s2_hit = !s2_live_reg;
            SCAN_SLOT:  s2_hit = s2_live_reg && (s2_slot_reg == last_slot);
            SCAN_MATCH: s2_hit = s2_live_reg && ((s_rdata & mask) == mask);
            default:    s2_hit = 1'b0;
        endcase
    end

    // scan control
    always_comb
    begin
        busy_next   = busy_reg;
        kind_next   = kind_reg;
        cnt_next    = cnt_reg;
        s1_vld_next = issue;
        s2_vld_next = s1_vld_reg;
        done_next   = 1'b0;
        hit_next    = 1'b0;
        if (cmd.start && !busy_reg)
        begin
            busy_next   = 1'b1;
            kind_next   = cmd.kind;
            cnt_next    = {1'b0, start_key};
            s1_vld_next = 1'b0;
            s2_vld_next = 1'b0;
        end
        else if (s2_vld_reg && s2_hit)
        begin
            busy_next   = 1'b0;
            s1_vld_next = 1'b0;
            s2_vld_next = 1'b0;
            done_next   = 1'b1;
            hit_next    = 1'b1;
        end
        else if (busy_reg && !issue && !s1_vld_reg && !s2_vld_reg)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + (KW+1)'(1);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            kind_reg   <= SCAN_FREE;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            kind_reg   <= kind_next;
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            done_reg   <= done_next;
            hit_reg    <= hit_next;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        s1_key_reg  <= cnt_reg[KW-1:0];
        s2_key_reg  <= s1_key_reg;
        s2_live_reg <= k_rdata[KW];
        s2_slot_reg <= k_rdata[KW-1:0];
        if (s2_vld_reg && s2_hit)
        begin
            hit_key_reg <= s2_key_reg;
            hit_sig_reg <= s_rdata;
        end
    end

    assign stat.done = done_reg;
    assign stat.hit  = hit_reg;
    assign hit_key   = hit_key_reg;
    assign hit_sig   = hit_sig_reg;

endmodule

[tb/slot_map_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_map_checker
// Watches both channels of the handle table, keeps its own copy of the key
// map, dense signatures and live count, works out the result of every input
// transaction and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module slot_map_checker
    import ehsm_pkg::*;
#(
    parameter int NUM_KEYS = MAX_HANDLES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [MODE_W-1:0]    mode,
    input  logic [KEY_W-1:0]     key,
    input  logic [COMP_W-1:0]    component,
    input  logic [MASK_W-1:0]    match_mask,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [KEY_W-1:0]     result_key,
    input  logic                 found,
    input  logic [SIG_OUT_W-1:0] signature,
    input  logic [STATUS_W-1:0]  status,
    input  logic [COUNT_W-1:0]   live_count,
    output int                   mismatches,
    output int                   open_cnt
);

    typedef struct packed {
        logic [KEY_W-1:0]     rkey;
        logic                 hit;
        logic [SIG_OUT_W-1:0] sig;
        logic [STATUS_W-1:0]  stat;
        logic [COUNT_W-1:0]   cnt;
    } slot_result_t;

    // shadow table
    logic                 key_live [NUM_KEYS];
    logic [KEY_W-1:0]     key_slot [NUM_KEYS];
    logic [SIG_OUT_W-1:0] slot_sig [NUM_KEYS];
    logic [COUNT_W-1:0]   live_n;

    slot_result_t pending_results [$];
    int           fail_n = 0;

    assign mismatches = fail_n;

    // apply one operation to the shadow table and return its result
    function automatic slot_result_t apply_slot_op(
        input logic [MODE_W-1:0] op,
        input logic [KEY_W-1:0]  k,
        input logic [COMP_W-1:0] c,
        input logic [MASK_W-1:0] m
    );
        slot_result_t         r;
        logic [KEY_W-1:0]     hole;
        logic [KEY_W-1:0]     last;
        logic [SIG_OUT_W-1:0] s;
        logic                 hit;

        r   = '0;
        hit = 1'b0;
        case (op)
            MODE_CREATE:
            begin
                // lowest free key takes the next dense slot
                r.stat = STAT_FULL;
                for (int i = 0; i < NUM_KEYS && !hit; i++)
                begin
                    if (!key_live[i])
                    begin
                        key_live[i] = 1'b1;
                        key_slot[i] = live_n[KEY_W-1:0];
                        r.sig       = slot_sig[live_n[KEY_W-1:0]];
                        live_n      = live_n + 1'b1;
                        r.rkey      = KEY_W'(i);
                        r.hit       = 1'b1;
                        r.stat      = STAT_OK;
                        hit         = 1'b1;
                    end
                end
            end
            MODE_DELETE:
            begin
                if (!key_live[k])
                    r.stat = STAT_DEAD;
                else
                begin
                    // swap-remove: last slot fills the hole, its key is remapped
                    hole           = key_slot[k];
                    live_n         = live_n - 1'b1;
                    last           = live_n[KEY_W-1:0];
                    slot_sig[hole] = slot_sig[last];
                    slot_sig[last] = '0;
                    for (int i = 0; i < NUM_KEYS && !hit; i++)
                    begin
                        if (key_live[i] && key_slot[i] == last)
                        begin
                            key_slot[i] = hole;
                            hit         = 1'b1;
                        end
                    end
                    key_live[k] = 1'b0;
                    key_slot[k] = '0;
                end
            end
            MODE_TOGGLE:
            begin
                if (!key_live[k])
                    r.stat = STAT_DEAD;
                else
                begin
                    if (c < SIG_OUT_W)
                        slot_sig[key_slot[k]] = slot_sig[key_slot[k]] ^ (SIG_OUT_W'(1) << c);
                    r.hit = 1'b1;
                    r.sig = slot_sig[key_slot[k]];
                end
            end
            MODE_EXISTS:
            begin
                if (key_live[k])
                begin
                    r.hit = 1'b1;
                    r.sig = slot_sig[key_slot[k]];
                end
            end
            MODE_MATCH:
            begin
                // first live key at or above the start whose signature covers the mask
                for (int i = k; i < NUM_KEYS && !hit; i++)
                begin
                    if (key_live[i])
                    begin
                        s = slot_sig[key_slot[i]];
                        if ((s & m) == m)
                        begin
                            r.rkey = KEY_W'(i);
                            r.hit  = 1'b1;
                            r.sig  = s;
                            hit    = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                // spare modes leave the table alone
            end
        endcase
        r.cnt = live_n;
        return r;
    endfunction

    // compare one output transaction against the oldest expectation
    function automatic void check_result(input slot_result_t got);
        slot_result_t want;

        if (pending_results.size() == 0)
        begin
            $error("result with nothing pending: result_key %0d live_count %0d",
                   got.rkey, got.cnt);
            fail_n++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.rkey !== want.rkey)
            begin
                $error("result_key: expected %0d, got %0d", want.rkey, got.rkey);
                fail_n++;
            end
            if (got.hit !== want.hit)
            begin
                $error("found: expected %0d, got %0d", want.hit, got.hit);
                fail_n++;
            end
            if (got.sig !== want.sig)
            begin
                $error("signature: expected 0x%02h, got 0x%02h", want.sig, got.sig);
                fail_n++;
            end
            if (got.stat !== want.stat)
            begin
                $error("status: expected %0d, got %0d", want.stat, got.stat);
                fail_n++;
            end
            if (got.cnt !== want.cnt)
            begin
                $error("live_count: expected %0d, got %0d", want.cnt, got.cnt);
                fail_n++;
            end
        end
    endfunction

    // sample both channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                key_live[i] = 1'b0;
                key_slot[i] = '0;
                slot_sig[i] = '0;
            end
            live_n = '0;
            pending_results.delete();
            open_cnt <= 0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_ready)
                check_result({result_key, found, signature, status, live_count});
            if (in_valid && in_ready === 1'b1)
                pending_results.push_back(apply_slot_op(mode, key, component, match_mask));
            open_cnt <= pending_results.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the entity handle slot map: a directed opening over every
// operation and corner, a long random run over a small key range with
// idling on both sides and a long output stall, then a quiet end with no
// idling. The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
    import ehsm_pkg::*;

    // spare operation codes the block must ignore
    localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    localparam logic [KEY_W-1:0] KEY_TOP   = {KEY_W{1'b1}};
    localparam int               HOLD_CYC  = 300;
    localparam int               SETTLE_CYC = 1100;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic [MODE_W-1:0]    mode       = MODE_EXISTS;
    logic [KEY_W-1:0]     key        = '0;
    logic [COMP_W-1:0]    component  = '0;
    logic [MASK_W-1:0]    match_mask = '0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    logic [KEY_W-1:0]     result_key;
    logic                 found;
    logic [SIG_OUT_W-1:0] signature;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   live_count;

    int   mismatches;
    int   open_cnt;

    // idling control shared with the receiver
    logic tx_idle   = 1'b1;
    logic rx_idle   = 1'b1;
    int   hold_tick = 0;
    int   op_count [8];

    entity_handle_slot_map_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .key        (key),
        .component  (component),
        .match_mask (match_mask),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_key (result_key),
        .found      (found),
        .signature  (signature),
        .status     (status),
        .live_count (live_count)
    );

    slot_map_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .key        (key),
        .component  (component),
        .match_mask (match_mask),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_key (result_key),
        .found      (found),
        .signature  (signature),
        .status     (status),
        .live_count (live_count),
        .mismatches (mismatches),
        .open_cnt   (open_cnt)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // offer one transaction and wait until it is taken
    task automatic issue_op(
        input logic [MODE_W-1:0] op,
        input logic [KEY_W-1:0]  k,
        input logic [COMP_W-1:0] c,
        input logic [MASK_W-1:0] m
    );
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        key        <= k;
        component  <= c;
        match_mask <= m;
        op_count[op]++;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
    endtask

    // sender pauses until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (open_cnt != 0)
            @(posedge clk);
    endtask

    // weighted random operation over a small key range, sparse masks
    task automatic issue_random(input int key_span);
        int                pick;
        logic [MODE_W-1:0] op;
        logic [KEY_W-1:0]  k;
        logic [MASK_W-1:0] m;

        pick = $urandom_range(0, 99);
        if (pick < 28)
            op = MODE_CREATE;
        else if (pick < 46)
            op = MODE_DELETE;
        else if (pick < 66)
            op = MODE_TOGGLE;
        else if (pick < 78)
            op = MODE_EXISTS;
        else if (pick < 95)
            op = MODE_MATCH;
        else if (pick < 97)
            op = MODE_RSVD5;
        else if (pick < 98)
            op = MODE_RSVD6;
        else
            op = MODE_RSVD7;
        if ($urandom_range(0, 9) == 0)
            k = KEY_W'($urandom);
        else
            k = KEY_W'($urandom_range(0, key_span));
        if ($urandom_range(0, 3) == 0)
            m = MASK_W'($urandom);
        else
            m = MASK_W'($urandom & $urandom & $urandom);
        issue_op(op, k, COMP_W'($urandom), m);
    endtask

    // receiver: random ready stretches, stall bursts and a long hold-off
    initial
    begin : receiver
        int hold_seen;

        hold_seen = 0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_tick != hold_seen)
            begin
                hold_seen = hold_tick;
                out_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
            end
            else if (rx_idle && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("timeout: results still outstanding %0d", open_cnt);
        $display("== FAIL ==");
        $finish;
    end

    // stimulus and verdict
    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, dead keys, spare modes
        issue_op(MODE_EXISTS, '0, '0, '0);
        issue_op(MODE_DELETE, 10'd5, '0, '0);
        issue_op(MODE_TOGGLE, KEY_TOP, 3'd7, '0);
        issue_op(MODE_MATCH, '0, '0, '0);
        issue_op(MODE_RSVD5, KEY_TOP, 3'd7, 8'hFF);
        issue_op(MODE_RSVD6, '0, '0, '0);
        issue_op(MODE_RSVD7, 10'd3, 3'd1, 8'h0F);

        // directed: a few creates, toggles at both ends of the signature
        repeat (4) issue_op(MODE_CREATE, '0, '0, '0);
        issue_op(MODE_TOGGLE, 10'd0, 3'd0, '0);
        issue_op(MODE_TOGGLE, 10'd0, 3'd7, '0);
        issue_op(MODE_TOGGLE, 10'd1, 3'd3, '0);
        issue_op(MODE_TOGGLE, 10'd3, 3'd7, '0);
        issue_op(MODE_EXISTS, 10'd0, '0, '0);
        issue_op(MODE_MATCH, '0, '0, 8'h81);
        issue_op(MODE_MATCH, 10'd1, '0, '0);
        issue_op(MODE_MATCH, '0, '0, 8'hFF);

        // directed: swap-remove from the middle, reuse of a freed key
        issue_op(MODE_DELETE, 10'd1, '0, '0);
        issue_op(MODE_EXISTS, 10'd3, '0, '0);
        issue_op(MODE_CREATE, KEY_TOP, 3'd7, 8'hFF);
        issue_op(MODE_DELETE, 10'd0, '0, '0);
        issue_op(MODE_DELETE, 10'd0, '0, '0);
        issue_op(MODE_EXISTS, KEY_TOP, '0, '0);
        issue_op(MODE_MATCH, KEY_TOP, '0, '0);
        drain_results();

        // random with idling, then a long output stall while offers continue
        repeat (150) issue_random(127);
        tx_idle = 1'b0;
        hold_tick <= hold_tick + 1;
        repeat (12) issue_random(127);
        tx_idle = 1'b1;
        repeat (60) issue_random(127);
        drain_results();

        // more random with idling on both sides
        repeat (160) issue_random(127);
        drain_results();

        // quiet end: no idling on either side
        rx_idle <= 1'b0;
        tx_idle = 1'b0;
        repeat (160) issue_random(127);
        issue_op(MODE_EXISTS, KEY_TOP, '0, '0);
        issue_op(MODE_TOGGLE, KEY_TOP, 3'd7, '0);
        issue_op(MODE_TOGGLE, KEY_TOP, 3'd0, '0);
        issue_op(MODE_MATCH, 10'd1000, '0, 8'h81);
        issue_op(MODE_MATCH, KEY_TOP, '0, 8'hFF);
        issue_op(MODE_DELETE, KEY_TOP, '0, '0);
        issue_op(MODE_DELETE, 10'd0, '0, '0);
        issue_op(MODE_CREATE, '0, '0, '0);
        issue_op(MODE_CREATE, '0, '0, '0);
        issue_op(MODE_CREATE, '0, '0, '0);
        issue_op(MODE_MATCH, '0, '0, '0);
        issue_op(MODE_EXISTS, '0, '0, '0);
        drain_results();

        // catch any stray result
        repeat (SETTLE_CYC) @(posedge clk);

        $display("ops: create %0d, delete %0d, toggle %0d, exists %0d, match %0d, spare %0d",
                 op_count[MODE_CREATE], op_count[MODE_DELETE], op_count[MODE_TOGGLE],
                 op_count[MODE_EXISTS], op_count[MODE_MATCH],
                 op_count[MODE_RSVD5] + op_count[MODE_RSVD6] + op_count[MODE_RSVD7]);
        $display("covered dead keys, spare modes, swap-remove, a long output stall and drains; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && open_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
